>>> rtl/core/mthd_pkg.sv
package mthd_pkg;

    localparam int POWER_W    = 32;
    localparam int GAIN_W     = 10;
    localparam int OFFSET_W   = 16;
    localparam int MASK_W     = 10;
    localparam int CHAN_OUT_W = 4;
    localparam int HCOUNT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int PROD_W     = POWER_W + GAIN_W;
    localparam int THR_W      = PROD_W + 1;
    localparam int M_DATA_W   = 24;

    localparam logic [GAIN_W-1:0]     GAIN_RST   = 10'd100;
    localparam logic [OFFSET_W-1:0]   OFFSET_RST = 16'd6554;
    localparam logic [MASK_W-1:0]     MASK_RST   = 10'd0;
    localparam logic [CHAN_OUT_W-1:0] OWN_RST    = 4'd4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN   = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_MASK   = 2'd2,
        CFG_OWN    = 2'd3
    } cfg_reg_t;

    // first member lands in the top bits, so hit_event ends up at bit 0
    typedef struct packed {
        logic [HCOUNT_W-1:0]   channel_hit_count;
        logic                  frozen_now;
        logic                  hit_flag;
        logic [CHAN_OUT_W-1:0] detected_channel;
        logic                  revived;
        logic                  hit_event;
    } result_t;

endpackage

>>> rtl/core/mthd_select.sv
module mthd_select #(
    parameter int NUM_CHANNELS = 10,
    parameter int CH_W         = 4
) (
    input  logic [NUM_CHANNELS-1:0][mthd_pkg::POWER_W-1:0] power,
    output logic [CH_W-1:0]                                max_ch,
    output logic [mthd_pkg::POWER_W-1:0]                   max_val,
    output logic [mthd_pkg::POWER_W-1:0]                   median
);

    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
    localparam logic [CNT_W-1:0] RANK = CNT_W'((NUM_CHANNELS - 1) / 2);

    logic [NUM_CHANNELS-1:0][NUM_CHANNELS-1:0] lt;
    logic [NUM_CHANNELS-1:0][NUM_CHANNELS-1:0] eq;
    logic [NUM_CHANNELS-1:0][CNT_W-1:0]        less_cnt;
    logic [NUM_CHANNELS-1:0][CNT_W-1:0]        eq_cnt;
    logic [NUM_CHANNELS-1:0]                   rank_hit;
    logic [NUM_CHANNELS-1:0]                   win;

    // lt[i][j]: channel j is below channel i
    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            for (int j = 0; j < NUM_CHANNELS; j++) begin
                lt[i][j] = power[j] < power[i];
                eq[i][j] = power[j] == power[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            less_cnt[i] = CNT_W'($countones(lt[i]));
            eq_cnt[i]   = CNT_W'($countones(eq[i]));
            rank_hit[i] = (less_cnt[i] <= RANK) && (RANK < less_cnt[i] + eq_cnt[i]);
            // ties go to the lowest channel: at least as high as all earlier ones, strictly above all later ones
            win[i] = 1'b1;
            for (int j = 0; j < NUM_CHANNELS; j++) begin
                if (j < i) begin
                    win[i] = win[i] & ~lt[j][i];
                end else if (j > i) begin
                    win[i] = win[i] & lt[i][j];
                end
            end
        end
    end

    // every rank hit carries the same value, and exactly one channel wins
    always_comb begin
        median  = '0;
        max_val = '0;
        max_ch  = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (rank_hit[i]) begin
                median = median | power[i];
            end
            if (win[i]) begin
                max_val = max_val | power[i];
                max_ch  = max_ch | CH_W'(i);
            end
        end
    end

endmodule

>>> rtl/core/median_threshold_hit_detector.sv
// an accepted transaction passes the input, select and threshold registers into the result register
// throughput: one transaction per cycle; the four-register pipeline stalls as a
// whole only while the result register holds a result that is not yet taken
// reset (aresetn low, synchronous): pipeline emptied, frozen and sticky flags
// cleared, all hit counters zeroed, configuration back to its defaults
module median_threshold_hit_detector #(
    parameter int NUM_CHANNELS = 10,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // power_ch0 .. power_chN-1, 32 bits each, channel 0 lowest
    input  logic [NUM_CHANNELS*mthd_pkg::POWER_W-1:0] s_tdata,
    // lockout_active
    input  logic                                 s_tuser,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // hit_event, revived, detected_channel[3:0], hit_flag, frozen_now,
    // channel_hit_count[15:0]
    output logic [mthd_pkg::M_DATA_W-1:0]        m_tdata,

    input  logic                                 cfg_wr_en,
    input  logic [mthd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mthd_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int CH_W = $clog2(NUM_CHANNELS);
    localparam int PW   = mthd_pkg::POWER_W;

    logic                                 adv;

    logic [mthd_pkg::GAIN_W-1:0]          gain_reg;
    logic [mthd_pkg::OFFSET_W-1:0]        offset_reg;
    logic [mthd_pkg::MASK_W-1:0]          mask_reg;
    logic [mthd_pkg::CHAN_OUT_W-1:0]      own_reg;

    logic                                 v1_reg, v2_reg, v3_reg, vo_reg;
    logic [NUM_CHANNELS-1:0][PW-1:0]      power1_reg;
    logic                                 lock1_reg, lock2_reg, lock3_reg;

    logic [CH_W-1:0]                      sel_ch;
    logic [PW-1:0]                        sel_max;
    logic [PW-1:0]                        sel_median;

    logic [CH_W-1:0]                      ch2_reg, ch3_reg;
    logic [PW-1:0]                        max2_reg, max3_reg;
    logic [PW-1:0]                        median2_reg;
    logic [mthd_pkg::THR_W-1:0]           thr3_reg;
    logic [mthd_pkg::PROD_W-1:0]          prod;

    logic                                 frozen_reg, frozen_next;
    logic                                 sticky_reg, sticky_next;
    logic [COUNT_WIDTH-1:0]               cnt_reg [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]               cnt_cur, cnt_next;
    logic                                 event_next, revived_next;
    logic [15:0]                          mask_ext;
    logic                                 exceed, masked, own_match;
    logic [31:0]                          cnt_wide;
    mthd_pkg::result_t                    res_reg, res_next;

    // the whole pipeline moves unless a finished result is stuck at the output
    assign adv      = !vo_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vo_reg;
    assign m_tdata  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= mthd_pkg::GAIN_RST;
            offset_reg <= mthd_pkg::OFFSET_RST;
            mask_reg   <= mthd_pkg::MASK_RST;
            own_reg    <= mthd_pkg::OWN_RST;
        end else if (cfg_wr_en) begin
            unique case (mthd_pkg::cfg_reg_t'(cfg_addr))
                mthd_pkg::CFG_GAIN:   gain_reg   <= cfg_wr_data[mthd_pkg::GAIN_W-1:0];
                mthd_pkg::CFG_OFFSET: offset_reg <= cfg_wr_data[mthd_pkg::OFFSET_W-1:0];
                mthd_pkg::CFG_MASK:   mask_reg   <= cfg_wr_data[mthd_pkg::MASK_W-1:0];
                mthd_pkg::CFG_OWN:    own_reg    <= cfg_wr_data[mthd_pkg::CHAN_OUT_W-1:0];
                default: ;
            endcase
        end
    end

    mthd_select #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .CH_W        (CH_W)
    ) u_select (
        .power  (power1_reg),
        .max_ch (sel_ch),
        .max_val(sel_max),
        .median (sel_median)
    );

    assign prod = mthd_pkg::PROD_W'(median2_reg) * mthd_pkg::PROD_W'(gain_reg);

    // payload stages, no reset needed
    always_ff @(posedge aclk) begin
        if (adv) begin
            power1_reg  <= s_tdata;
            lock1_reg   <= s_tuser;
            ch2_reg     <= sel_ch;
            max2_reg    <= sel_max;
            median2_reg <= sel_median;
            lock2_reg   <= lock1_reg;
            ch3_reg     <= ch2_reg;
            max3_reg    <= max2_reg;
            thr3_reg    <= mthd_pkg::THR_W'(prod) + mthd_pkg::THR_W'(offset_reg);
            lock3_reg   <= lock2_reg;
        end
    end

    // decision stage: threshold compare and state update
    always_comb begin
        mask_ext     = 16'(mask_reg);
        exceed       = mthd_pkg::THR_W'(max3_reg) > thr3_reg;
        masked       = mask_ext[4'(ch3_reg)];
        own_match    = 4'(ch3_reg) == own_reg;
        cnt_cur      = cnt_reg[ch3_reg];
        frozen_next  = frozen_reg;
        sticky_next  = sticky_reg;
        event_next   = 1'b0;
        revived_next = 1'b0;
        if (!lock3_reg) begin
            if (exceed && !masked) begin
                if (frozen_reg && own_match) begin
                    frozen_next  = 1'b0;
                    event_next   = 1'b1;
                    revived_next = 1'b1;
                end else if (!frozen_reg && !own_match) begin
                    frozen_next = 1'b1;
                    event_next  = 1'b1;
                end
                if (event_next) begin
                    sticky_next = 1'b1;
                end
            end else begin
                sticky_next = 1'b0;
            end
        end
        cnt_next = cnt_cur + COUNT_WIDTH'(event_next);
        cnt_wide = 32'(cnt_next);

        res_next.hit_event         = event_next;
        res_next.revived           = revived_next;
        res_next.detected_channel  = 4'(ch3_reg);
        res_next.hit_flag          = sticky_next;
        res_next.frozen_now        = frozen_next;
        res_next.channel_hit_count = cnt_wide[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            vo_reg     <= 1'b0;
            frozen_reg <= 1'b0;
            sticky_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
            if (v3_reg) begin
                frozen_reg       <= frozen_next;
                sticky_reg       <= sticky_next;
                cnt_reg[ch3_reg] <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v3_reg) begin
            res_reg <= res_next;
        end
    end

    // an event always sets the sticky flag, and a revive leaves the block running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.hit_event) |->
            (res_reg.hit_flag && (res_reg.frozen_now != res_reg.revived)))
        else $error("event result inconsistent with flags");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !res_reg.hit_event) |-> !res_reg.revived)
        else $error("revive reported without an event");

    // the frozen flag only moves together with a freshly loaded event result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (frozen_reg != $past(frozen_reg)) |-> (m_tvalid && res_reg.hit_event))
        else $error("frozen flag changed without an event");

endmodule
